### hw/rtl/sfm_pkg.sv
package sfm_pkg;

    localparam int FRAC_W = 23;
    localparam int EXP_W  = 8;
    localparam int MANT_W = FRAC_W + 1;
    localparam int PROD_W = 2 * MANT_W;
    localparam int EXP_BIAS = 127;
    localparam int EXP_MAX  = 254;

    typedef enum logic [1:0] {
        ST_NORMAL    = 2'd0,
        ST_ZERO      = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    // Control and operand data handed from one cell to the next.
    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic                  sign;
        logic [EXP_W+1:0]      exp_sum;
        logic [MANT_W-1:0]     mant_a;
        logic [MANT_W-1:0]     mant_b;
    } sfm_ctl_t;

endpackage

### hw/rtl/single_float_multiplier.sv
// Truncating single-precision multiplier. An operand pair is taken in every
// clock cycle (busy is always low) and its result appears on product and
// status, marked by done for one cycle, after passing through the chain of
// cells: an operand-decode register, the registered significand multiplier
// and the normalise and range-check register. The receiver cannot stall the
// result.
module single_float_multiplier
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        done,
    output logic [31:0] product,
    output logic [1:0]  status
);
    import sfm_pkg::*;

    sfm_ctl_t          ctl_reg;
    sfm_ctl_t          ctl_next;
    logic              m_valid;
    logic              m_zero;
    logic              m_sign;
    logic [EXP_W+1:0]  m_exp;
    logic [PROD_W-1:0] m_prod;

    assign busy = 1'b0;

    // Decode the operands into sign, exponent sum and significands.
    always_comb
    begin
        ctl_next.valid   = start;
        ctl_next.zero    = (operand_a[30:0] == '0) || (operand_b[30:0] == '0);
        ctl_next.sign    = operand_a[31] ^ operand_b[31];
        ctl_next.exp_sum = (EXP_W+2)'(operand_a[30:23]) + (EXP_W+2)'(operand_b[30:23])
                           - (EXP_W+2)'(EXP_BIAS);
        ctl_next.mant_a  = {1'b1, operand_a[FRAC_W-1:0]};
        ctl_next.mant_b  = {1'b1, operand_b[FRAC_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    sfm_mul_cell u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl_reg),
        .valid_out (m_valid),
        .zero_out  (m_zero),
        .sign_out  (m_sign),
        .exp_out   (m_exp),
        .prod_out  (m_prod)
    );

    sfm_norm_cell u_norm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (m_valid),
        .zero_in    (m_zero),
        .sign_in    (m_sign),
        .exp_in     (m_exp),
        .prod_in    (m_prod),
        .valid_out  (done),
        .word_out   (product),
        .status_out (status)
    );
endmodule

### hw/rtl/sfm_mul_cell.sv
// One cell of the multiplier chain: multiplies the significands and hands the
// raw product on with the operand control data.
module sfm_mul_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfm_pkg::sfm_ctl_t             ctl_in,
    output logic                          valid_out,
    output logic                          zero_out,
    output logic                          sign_out,
    output logic [sfm_pkg::EXP_W+1:0]     exp_out,
    output logic [sfm_pkg::PROD_W-1:0]    prod_out
);
    import sfm_pkg::*;

    logic                valid_reg;
    logic                zero_reg;
    logic                sign_reg;
    logic [EXP_W+1:0]    exp_reg;
    logic [PROD_W-1:0]   prod_reg;

    // The valid flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    // The 24 by 24 bit significand product is registered.
    always_ff @(posedge clk)
    begin
        zero_reg <= ctl_in.zero;
        sign_reg <= ctl_in.sign;
        exp_reg  <= ctl_in.exp_sum;
        prod_reg <= PROD_W'(ctl_in.mant_a) * PROD_W'(ctl_in.mant_b);
    end

    assign valid_out = valid_reg;
    assign zero_out  = zero_reg;
    assign sign_out  = sign_reg;
    assign exp_out   = exp_reg;
    assign prod_out  = prod_reg;
endmodule

### hw/rtl/sfm_norm_cell.sv
// Final cell: normalises, checks the exponent range and registers the result.
module sfm_norm_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic                          zero_in,
    input  logic                          sign_in,
    input  logic [sfm_pkg::EXP_W+1:0]     exp_in,
    input  logic [sfm_pkg::PROD_W-1:0]    prod_in,
    output logic                          valid_out,
    output logic [31:0]                   word_out,
    output logic [1:0]                    status_out
);
    import sfm_pkg::*;

    logic              valid_reg;
    logic [31:0]       word_reg;
    logic [31:0]       word_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [EXP_W+1:0]  exp_adj;
    logic [FRAC_W-1:0] frac;

    // Normalise by one place when the top product bit is set, then range check.
    // The exponent is held as a signed ten-bit value.
    always_comb
    begin
        if (prod_in[PROD_W-1])
        begin
            frac    = prod_in[PROD_W-2 -: FRAC_W];
            exp_adj = exp_in + (EXP_W+2)'(1);
        end
        else
        begin
            frac    = prod_in[PROD_W-3 -: FRAC_W];
            exp_adj = exp_in;
        end
        word_next = '0;
        if (zero_in)
        begin
            status_next = ST_ZERO;
        end
        else if ($signed(exp_adj) < $signed((EXP_W+2)'(1)))
        begin
            status_next = ST_UNDERFLOW;
        end
        else if ($signed(exp_adj) > $signed((EXP_W+2)'(EXP_MAX)))
        begin
            status_next = ST_OVERFLOW;
        end
        else
        begin
            status_next = ST_NORMAL;
            word_next   = {sign_in, exp_adj[EXP_W-1:0], frac};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        status_reg <= status_next;
    end

    assign valid_out  = valid_reg;
    assign word_out   = word_reg;
    assign status_out = status_reg;
endmodule

### hw/rtl/sfm_checker.sv
// Port-level checks on the multiplier.
module sfm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] operand_a,
    input logic [31:0] operand_b,
    input logic        done,
    input logic [31:0] product,
    input logic [1:0]  status
);
    import sfm_pkg::*;

    // Every transfer gives exactly one result, and every result follows a transfer.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ##3 (done == $past(start && !busy, 3)))
        else $error("result strobe does not follow transfer");

    // A zero first operand gives status zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operand_a[30:0] == '0)) |-> ##3 (status == ST_ZERO))
        else $error("zero operand not flagged");

    // Any non-normal status carries a zero product.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_NORMAL)) |-> (product == '0))
        else $error("product not cleared on exception");

    // The product sign is the XOR of the operand signs.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NORMAL)) |->
            (product[31] == ($past(operand_a[31], 3) ^ $past(operand_b[31], 3))))
        else $error("wrong product sign");
endmodule

bind single_float_multiplier sfm_checker u_sfm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .done      (done),
    .product   (product),
    .status    (status)
);

### sim/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sfm_pkg::*;

    localparam int LATENCY = 3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        done;
    logic [31:0] product;
    logic [1:0]  status;

    typedef struct {
        logic [31:0] word;
        status_t     code;
    } mul_result_t;

    mul_result_t pending_products[$];
    int          error_count;
    int          sender_idle_pct;

    single_float_multiplier dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .done      (done),
        .product   (product),
        .status    (status)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Truncating multiply of two single-precision words.
    function automatic mul_result_t multiply_words(logic [31:0] a, logic [31:0] b);
        mul_result_t           res;
        logic [EXP_W-1:0]      ea;
        logic [EXP_W-1:0]      eb;
        logic [PROD_W-1:0]     prod;
        logic [FRAC_W-1:0]     frac;
        int                    exp_val;
        ea = a[30:23];
        eb = b[30:23];
        res.word = '0;
        if ((ea == 0 && a[22:0] == 0) || (eb == 0 && b[22:0] == 0))
        begin
            res.code = ST_ZERO;
            return res;
        end
        exp_val = int'(ea) + int'(eb) - EXP_BIAS;
        prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
        if (prod[PROD_W-1])
        begin
            frac = prod[46:24];
            exp_val++;
        end
        else
        begin
            frac = prod[45:23];
        end
        if (exp_val < 1)
            res.code = ST_UNDERFLOW;
        else if (exp_val > EXP_MAX)
            res.code = ST_OVERFLOW;
        else
        begin
            res.code = ST_NORMAL;
            res.word = {a[31] ^ b[31], exp_val[7:0], frac};
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Send one operand pair, with a random idle gap beforehand.
    task automatic send_pair(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_products.push_back(multiply_words(a, b));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_products.size() != 0)
            @(posedge clk);
    endtask

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        mul_result_t want;
        if (rst_n && done)
        begin
            if (pending_products.size() == 0)
            begin
                report_mismatch("unexpected result", product, 32'd0);
            end
            else
            begin
                want = pending_products.pop_front();
                if (status !== want.code)
                    report_mismatch("status", {30'd0, status}, {30'd0, want.code});
                if (product !== want.word)
                    report_mismatch("product", product, want.word);
            end
        end
    end

    function automatic logic [31:0] make_word(logic s, logic [7:0] e, logic [22:0] f);
        return {s, e, f};
    endfunction

    // Extremes of the fields and each special case.
    task automatic test_directed();
        send_pair(32'h0000_0000, 32'h3F80_0000);   // zero first operand
        send_pair(32'h4000_0000, 32'h8000_0000);   // negative zero second
        send_pair(32'h8000_0000, 32'h0000_0000);
        send_pair(32'h3F80_0000, 32'h3F80_0000);   // one times one
        send_pair(32'hBFC0_0000, 32'h4040_0000);   // product top bit set
        send_pair(32'h3FFF_FFFF, 32'h3FFF_FFFF);
        send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow
        send_pair(32'h0080_0000, 32'h0080_0000);   // underflow
        send_pair(32'h0000_0001, 32'h3F80_0000);   // denormal taken as normal
        send_pair(32'h7F80_0000, 32'h3F80_0000);   // infinity taken as normal
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h7FC0_0000, 32'h0000_0001);
        send_pair(32'h3F80_0000, 32'h7F00_0000);   // largest exponent in range
        send_pair(32'h3F80_0000, 32'h0080_0000);   // smallest exponent in range
        send_pair(32'h3F00_0000, 32'h0080_0000);   // just below range
        send_pair(32'h3FFF_FFFF, 32'h7EFF_FFFF);   // largest exponent, reached by normalising
        send_pair(32'h8000_0001, 32'hFFFF_FFFE);
    endtask

    // Random operands; some have a zero exponent field, some exponents near the bias.
    task automatic test_random(int count);
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = $urandom;
            b = $urandom;
            case ($urandom_range(9))
                0: a = make_word(a[31], 8'd0, ($urandom_range(1) != 0) ? 23'd0 : a[22:0]);
                1: b = make_word(b[31], 8'd0, ($urandom_range(1) != 0) ? 23'd0 : b[22:0]);
                2, 3, 4, 5:
                begin
                    a[30:23] = 8'($urandom_range(190, 64));
                    b[30:23] = 8'($urandom_range(190, 64));
                end
                6: a[30:23] = 8'($urandom_range(255, 200));
                default: ;
            endcase
            send_pair(a, b);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operand_a = '0;
        operand_b = '0;
        error_count = 0;
        sender_idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain_results();

        sender_idle_pct = 29;
        test_random(600);
        drain_results();
        sender_idle_pct = 82;
        test_random(400);
        sender_idle_pct = 0;
        test_random(850);
        drain_results();

        repeat (LATENCY + 4) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog against a hung run.
    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/sfm_pkg.sv
hw/rtl/sfm_mul_cell.sv
hw/rtl/sfm_norm_cell.sv
hw/rtl/single_float_multiplier.sv
hw/rtl/sfm_checker.sv
sim/testbench.sv
